### design/bsrc_pkg.sv
// bsrc_pkg: shared types and constants for the Banker's safety and request checker.
// Used by bsrc_ctrl, bsrc_dp and the top level. No dependencies.
`default_nettype none
package bsrc_pkg;
	localparam int MAX_PROCS = 16;
	localparam int MAX_RES   = 8;
	localparam int CNT_W     = 8;
	localparam int WORK_W    = 12;
	localparam int PROC_W    = $clog2(MAX_PROCS);
	localparam int RES_W     = $clog2(MAX_RES);
	localparam int NP_W      = PROC_W + 1;
	localparam int NR_W      = RES_W + 1;
	localparam int ADDR_W    = PROC_W + RES_W;

	typedef enum logic [2:0] {
		CMD_SET_AVAIL = 3'd0,
		CMD_SET_MAX   = 3'd1,
		CMD_SET_ALLOC = 3'd2,
		CMD_STAGE_REQ = 3'd3,
		CMD_SAFETY    = 3'd4,
		CMD_REQUEST   = 3'd5
	} cmd_code_t;

	typedef enum logic [2:0] {
		ST_SAFE    = 3'd0,
		ST_UNSAFE  = 3'd1,
		ST_CLAIM   = 3'd2,
		ST_WAIT    = 3'd3,
		ST_GRANTED = 3'd4,
		ST_DENIED  = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_PROC, S_FIT, S_FWAIT, S_DEC, S_UNSAFE, S_EMIT,
		S_CSWEEP, S_CWAIT, S_CDEC, S_GRANT, S_ROLL, S_ONE
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              work_init;
		logic              rd_en;
		logic              rd_claim;
		logic [PROC_W-1:0] row;
		logic [RES_W-1:0]  col;
		logic              acc_clr;
		logic              grant_proc;
		logic [PROC_W-1:0] order_idx;
		logic              avail_take;
		logic              avail_give;
		logic              wr_en;
		logic              wr_add;
		logic              out_load;
		status_t           out_status;
		logic              out_from_seq;
		logic [PROC_W-1:0] out_proc;
		logic              out_last;
	} ctl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic fit;
		logic claim_bad;
		logic wait_bad;
		logic fin;
		logic out_free;
	} dp_stat_t;
endpackage
`default_nettype wire

### design/bsrc_dp.sv
// bsrc_dp: datapath with the max/allocation memories, vectors, work, finish marks,
// safe order and the output register. Depends on bsrc_pkg.
`default_nettype none
module bsrc_dp (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_accept,
	input  wire [2:0]                  cmd,
	input  wire [bsrc_pkg::PROC_W-1:0] proc_index,
	input  wire [bsrc_pkg::RES_W-1:0]  res_index,
	input  wire [bsrc_pkg::CNT_W-1:0]  value,
	input  wire [bsrc_pkg::NR_W-1:0]   nr,
	input  bsrc_pkg::ctl_cmd_t         ctl,
	output bsrc_pkg::dp_stat_t         stat,
	input  wire                        out_stall,
	output logic                       out_valid,
	output logic [2:0]                 status,
	output logic [bsrc_pkg::PROC_W-1:0] seq_proc,
	output logic                       last
);
	import bsrc_pkg::*;

	logic [CNT_W-1:0]  max_mem   [MAX_PROCS*MAX_RES];
	logic [CNT_W-1:0]  alloc_mem [MAX_PROCS*MAX_RES];
	logic [CNT_W-1:0]  avail_q   [MAX_RES];
	logic [CNT_W-1:0]  staged_q  [MAX_RES];
	logic [WORK_W-1:0] work_q    [MAX_RES];
	logic [CNT_W-1:0]  row_q     [MAX_RES];
	logic [CNT_W-1:0]  sav_q     [MAX_RES];
	logic [PROC_W-1:0] order_q   [MAX_PROCS];
	logic [MAX_PROCS-1:0] fin_q;
	logic [CNT_W-1:0]  max_s1, alloc_s1;
	logic [RES_W-1:0]  col_s1;
	logic              rd_v_s1, claim_s1;
	logic              fit_q, claim_bad_q, wait_bad_q;
	logic              out_valid_q, last_q;
	status_t           status_q;
	logic [PROC_W-1:0] proc_q;
	logic [ADDR_W-1:0] rd_addr, wr_addr;
	logic [CNT_W-1:0]  wr_data;
	logic              wr_alloc;
	logic [WORK_W:0]   fit_sum;
	logic              fit_fail, claim_fail, wait_fail;
	logic [CNT_W:0]    claim_sum;

	assign rd_addr = {ctl.row, ctl.col};

	// Memory read port, data registered
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			max_s1   <= max_mem[rd_addr];
			alloc_s1 <= alloc_mem[rd_addr];
			col_s1   <= ctl.col;
			claim_s1 <= ctl.rd_claim;
		end
	end

	// Allocation write: load command or grant/rollback sweep
	always_comb begin
		wr_alloc = 1'b0;
		wr_addr  = {ctl.row, ctl.col};
		wr_data  = ctl.wr_add ? sav_q[ctl.col] + staged_q[ctl.col] : sav_q[ctl.col];
		if (in_accept && cmd == CMD_SET_ALLOC) begin
			wr_alloc = 1'b1;
			wr_addr  = {proc_index, res_index};
			wr_data  = value;
		end else if (ctl.wr_en) begin
			wr_alloc = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && cmd == CMD_SET_MAX)
			max_mem[{proc_index, res_index}] <= value;
		if (wr_alloc)
			alloc_mem[wr_addr] <= wr_data;
	end

	// Per-element checks on the registered read data
	assign fit_sum    = {1'b0, work_q[col_s1]} + {{(WORK_W+1-CNT_W){1'b0}}, alloc_s1};
	assign fit_fail   = {{(WORK_W+1-CNT_W){1'b0}}, max_s1} > fit_sum;
	assign claim_sum  = {1'b0, staged_q[col_s1]} + {1'b0, alloc_s1};
	assign claim_fail = claim_sum > {1'b0, max_s1};
	assign wait_fail  = staged_q[col_s1] > avail_q[col_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1     <= 1'b0;
			fit_q       <= 1'b0;
			claim_bad_q <= 1'b0;
			wait_bad_q  <= 1'b0;
		end else begin
			rd_v_s1 <= ctl.rd_en;
			if (ctl.acc_clr) begin
				fit_q       <= 1'b1;
				claim_bad_q <= 1'b0;
				wait_bad_q  <= 1'b0;
			end else if (rd_v_s1) begin
				if (claim_s1) begin
					if (claim_fail) claim_bad_q <= 1'b1;
					if (wait_fail)  wait_bad_q  <= 1'b1;
				end else if (fit_fail) begin
					fit_q <= 1'b0;
				end
			end
		end
	end

	// Row buffers: allocation row for the grant, saved row for rollback
	always_ff @(posedge clk) begin
		if (rd_v_s1) begin
			row_q[col_s1] <= alloc_s1;
			if (claim_s1)
				sav_q[col_s1] <= alloc_s1;
		end
	end

	// Vectors: available, work, finish marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_RES; j++) begin
				avail_q[j] <= '0;
				work_q[j]  <= '0;
			end
			fin_q <= '0;
		end else begin
			if (in_accept && cmd == CMD_SET_AVAIL)
				avail_q[res_index] <= value;
			for (int j = 0; j < MAX_RES; j++) begin
				if (j < int'(nr)) begin
					if (ctl.avail_take) avail_q[j] <= avail_q[j] - staged_q[j];
					if (ctl.avail_give) avail_q[j] <= avail_q[j] + staged_q[j];
				end
			end
			if (ctl.work_init) begin
				for (int j = 0; j < MAX_RES; j++)
					work_q[j] <= {{(WORK_W-CNT_W){1'b0}}, avail_q[j]};
				fin_q <= '0;
			end
			if (ctl.grant_proc) begin
				for (int j = 0; j < MAX_RES; j++) begin
					if (j < int'(nr)) begin
						if (work_q[j] > {WORK_W{1'b1}} - {{(WORK_W-CNT_W){1'b0}}, row_q[j]})
							work_q[j] <= {WORK_W{1'b1}};
						else
							work_q[j] <= work_q[j] + {{(WORK_W-CNT_W){1'b0}}, row_q[j]};
					end
				end
				fin_q[ctl.row] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && cmd == CMD_STAGE_REQ)
			staged_q[res_index] <= value;
		if (ctl.grant_proc)
			order_q[ctl.order_idx] <= ctl.row;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status_q <= ctl.out_status;
			proc_q   <= ctl.out_from_seq ? order_q[ctl.order_idx] : ctl.out_proc;
			last_q   <= ctl.out_last;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign seq_proc  = proc_q;
	assign last      = last_q;

	assign stat.fit       = fit_q;
	assign stat.claim_bad = claim_bad_q;
	assign stat.wait_bad  = wait_bad_q;
	assign stat.fin       = fin_q[ctl.row];
	assign stat.out_free  = !out_valid_q || !out_stall;
endmodule
`default_nettype wire

### design/bsrc_ctrl.sv
// bsrc_ctrl: sequencer for safety passes, request checks, grant/rollback and result emit.
// Depends on bsrc_pkg; drives bsrc_dp through ctl_cmd_t.
`default_nettype none
module bsrc_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        in_valid,
	output logic                       in_stall,
	input  wire [2:0]                  cmd,
	input  wire [bsrc_pkg::PROC_W-1:0] proc_index,
	input  wire [bsrc_pkg::NP_W-1:0]   np,
	input  wire [bsrc_pkg::NR_W-1:0]   nr,
	input  bsrc_pkg::dp_stat_t         stat,
	output bsrc_pkg::ctl_cmd_t         ctl
);
	import bsrc_pkg::*;

	state_t            state_q, state_d;
	logic [NP_W-1:0]   i_q, i_d;
	logic [RES_W-1:0]  j_q, j_d;
	logic [NP_W-1:0]   cnt_q, cnt_d;
	logic [PROC_W-1:0] e_q, e_d;
	logic              prog_q, prog_d;
	logic              req_q, req_d;
	logic [PROC_W-1:0] rp_q, rp_d;
	status_t           one_st_q, one_st_d;
	logic [PROC_W-1:0] one_p_q, one_p_d;
	logic              j_last, e_last;

	assign j_last   = ({1'b0, j_q} + NR_W'(1)) == nr;
	assign e_last   = ({1'b0, e_q} + NP_W'(1)) == np;
	assign in_stall = state_q != S_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			i_q      <= '0;
			j_q      <= '0;
			cnt_q    <= '0;
			e_q      <= '0;
			prog_q   <= 1'b0;
			req_q    <= 1'b0;
			rp_q     <= '0;
			one_st_q <= ST_SAFE;
			one_p_q  <= '0;
		end else begin
			state_q  <= state_d;
			i_q      <= i_d;
			j_q      <= j_d;
			cnt_q    <= cnt_d;
			e_q      <= e_d;
			prog_q   <= prog_d;
			req_q    <= req_d;
			rp_q     <= rp_d;
			one_st_q <= one_st_d;
			one_p_q  <= one_p_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		j_d      = j_q;
		cnt_d    = cnt_q;
		e_d      = e_q;
		prog_d   = prog_q;
		req_d    = req_q;
		rp_d     = rp_q;
		one_st_d = one_st_q;
		one_p_d  = one_p_q;
		ctl            = '0;
		ctl.out_status = ST_SAFE;
		ctl.row        = i_q[PROC_W-1:0];
		ctl.col        = j_q;
		ctl.order_idx  = cnt_q[PROC_W-1:0];
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (cmd == CMD_SAFETY) begin
						req_d   = 1'b0;
						state_d = S_INIT;
					end else if (cmd == CMD_REQUEST) begin
						req_d = 1'b1;
						rp_d  = proc_index;
						if ({1'b0, proc_index} >= np) begin
							one_st_d = ST_CLAIM;
							one_p_d  = proc_index;
							state_d  = S_ONE;
						end else begin
							ctl.acc_clr = 1'b1;
							j_d         = '0;
							state_d     = S_CSWEEP;
						end
					end
				end
			end
			// Claim and availability sweep over the requester's row
			S_CSWEEP: begin
				ctl.rd_en    = 1'b1;
				ctl.rd_claim = 1'b1;
				ctl.row      = rp_q;
				if (j_last) state_d = S_CWAIT;
				else j_d = j_q + RES_W'(1);
			end
			S_CWAIT: state_d = S_CDEC;
			S_CDEC: begin
				one_p_d = rp_q;
				if (stat.claim_bad) begin
					one_st_d = ST_CLAIM;
					state_d  = S_ONE;
				end else if (stat.wait_bad) begin
					one_st_d = ST_WAIT;
					state_d  = S_ONE;
				end else begin
					ctl.avail_take = 1'b1;
					j_d            = '0;
					state_d        = S_GRANT;
				end
			end
			// Tentative grant written into the allocation row
			S_GRANT: begin
				ctl.wr_en  = 1'b1;
				ctl.wr_add = 1'b1;
				ctl.row    = rp_q;
				if (j_last) state_d = S_INIT;
				else j_d = j_q + RES_W'(1);
			end
			S_INIT: begin
				ctl.work_init = 1'b1;
				i_d    = '0;
				cnt_d  = '0;
				prog_d = 1'b0;
				state_d = S_PROC;
			end
			// Pass walk over processes
			S_PROC: begin
				if (i_q == np) begin
					if (cnt_q == np) begin
						e_d     = '0;
						state_d = S_EMIT;
					end else if (!prog_q) begin
						state_d = S_UNSAFE;
					end else begin
						i_d    = '0;
						prog_d = 1'b0;
					end
				end else if (stat.fin) begin
					i_d = i_q + NP_W'(1);
				end else begin
					ctl.acc_clr = 1'b1;
					j_d         = '0;
					state_d     = S_FIT;
				end
			end
			S_FIT: begin
				ctl.rd_en = 1'b1;
				if (j_last) state_d = S_FWAIT;
				else j_d = j_q + RES_W'(1);
			end
			S_FWAIT: state_d = S_DEC;
			S_DEC: begin
				if (stat.fit) begin
					ctl.grant_proc = 1'b1;
					cnt_d  = cnt_q + NP_W'(1);
					prog_d = 1'b1;
				end
				i_d     = i_q + NP_W'(1);
				state_d = S_PROC;
			end
			S_UNSAFE: begin
				if (req_q) begin
					ctl.avail_give = 1'b1;
					j_d     = '0;
					state_d = S_ROLL;
				end else begin
					one_st_d = ST_UNSAFE;
					one_p_d  = '0;
					state_d  = S_ONE;
				end
			end
			// Restore the saved allocation row
			S_ROLL: begin
				ctl.wr_en = 1'b1;
				ctl.row   = rp_q;
				if (j_last) begin
					one_st_d = ST_DENIED;
					one_p_d  = rp_q;
					state_d  = S_ONE;
				end else begin
					j_d = j_q + RES_W'(1);
				end
			end
			S_EMIT: begin
				ctl.order_idx = e_q;
				if (stat.out_free) begin
					ctl.out_load     = 1'b1;
					ctl.out_status   = req_q ? ST_GRANTED : ST_SAFE;
					ctl.out_from_seq = 1'b1;
					ctl.out_last     = e_last;
					if (e_last) state_d = S_IDLE;
					else e_d = e_q + PROC_W'(1);
				end
			end
			S_ONE: begin
				if (stat.out_free) begin
					ctl.out_load   = 1'b1;
					ctl.out_status = one_st_q;
					ctl.out_proc   = one_p_q;
					ctl.out_last   = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

### design/bankers_safety_and_request_check.sv
// Top level of the Banker's safety and request checker: APB registers, controller, datapath.
// Depends on bsrc_pkg, bsrc_ctrl and bsrc_dp.
`default_nettype none
// Load commands (set available, set max, set allocation, stage request) are taken while
// idle and give no result. A safety check copies available into work and walks the active
// processes in index order, pass after pass; each unfinished process gets one read of the
// max/allocation memories per active resource, a wait for the registered read data and one
// decision, and a finished one is skipped. A request evaluation adds a claim sweep and a
// grant write over the requester's row, and a rollback write of that row when unsafe. One
// item is worked at a time; results leave through an output register, so the next item is
// taken while the final result waits.
module bankers_safety_and_request_check (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        psel,
	input  wire        penable,
	input  wire        pwrite,
	input  wire [2:0]  paddr,
	input  wire [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire [2:0]  cmd,
	input  wire [3:0]  proc_index,
	input  wire [2:0]  res_index,
	input  wire [7:0]  value,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [2:0] status,
	output logic [3:0] seq_proc,
	output logic       last
);
	import bsrc_pkg::*;

	localparam logic REG_PROCS = 1'b0;
	localparam logic REG_RES   = 1'b1;

	logic [4:0]      procs_q;
	logic [3:0]      res_q;
	logic [NP_W-1:0] np;
	logic [NR_W-1:0] nr;
	logic            in_accept;
	ctl_cmd_t        ctl;
	dp_stat_t        stat;

	// Configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			procs_q <= 5'd16;
			res_q   <= 4'd8;
		end else if (psel && penable && pwrite) begin
			if (paddr[2] == REG_PROCS) procs_q <= pwdata[4:0];
			else res_q <= pwdata[3:0];
		end
	end
	assign prdata = (paddr[2] == REG_RES) ? {28'd0, res_q} : {27'd0, procs_q};

	// Active sizes, saturated into range
	always_comb begin
		if (procs_q == '0) np = NP_W'(1);
		else if (procs_q > 5'(MAX_PROCS)) np = NP_W'(MAX_PROCS);
		else np = procs_q[NP_W-1:0];
		if (res_q == '0) nr = NR_W'(1);
		else if (res_q > 4'(MAX_RES)) nr = NR_W'(MAX_RES);
		else nr = res_q[NR_W-1:0];
	end

	assign in_accept = in_valid && !in_stall;

	bsrc_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cmd        (cmd),
		.proc_index (proc_index),
		.np         (np),
		.nr         (nr),
		.stat       (stat),
		.ctl        (ctl)
	);

	bsrc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_accept  (in_accept),
		.cmd        (cmd),
		.proc_index (proc_index),
		.res_index  (res_index),
		.value      (value),
		.nr         (nr),
		.ctl        (ctl),
		.stat       (stat),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.status     (status),
		.seq_proc   (seq_proc),
		.last       (last)
	);
endmodule
`default_nettype wire

### design/bsrc_checker.sv
// bsrc_checker: port-level assertions for the Banker's checker, bound to the top level.
// Depends on bsrc_pkg for the status codes and on the top level's ports.
`default_nettype none
module bsrc_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       pready,
	input wire       out_valid,
	input wire       out_stall,
	input wire [2:0] status,
	input wire [3:0] seq_proc,
	input wire       last
);
	import bsrc_pkg::*;

	// A stalled result stays valid
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid) else $error("result dropped under stall");

	// A stalled result keeps its status
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status)) else $error("status changed under stall");

	// Single results always close the run
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_UNSAFE || status == ST_CLAIM || status == ST_WAIT ||
		status == ST_DENIED) |-> last) else $error("single result without last");

	// Unsafe result names process zero
	a_unsafe_proc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_UNSAFE |-> seq_proc == 4'd0)
		else $error("unsafe with process");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");
endmodule

bind bankers_safety_and_request_check bsrc_checker u_bsrc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.pready    (pready),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.seq_proc  (seq_proc),
	.last      (last)
);
`default_nettype wire

### bench/tb.sv
// Testbench for bankers_safety_and_request_check: random and directed load, safety and
// request items, checked against an in-bench model of the Banker's engine.
// Depends on bsrc_pkg and the top level of the block.
`timescale 1ns / 1ps
module tb;
	import bsrc_pkg::*;

	localparam int WORK_TOP = 4095;
	localparam int WDOG_LIMIT = 200000;
	localparam logic [2:0] REG_NPROC = 3'd0;
	localparam logic [2:0] REG_NRES  = 3'd4;

	typedef struct packed {
		logic [2:0] cmd;
		logic [3:0] proc;
		logic [2:0] res;
		logic [7:0] value;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] proc;
		logic       last;
	} res_t;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 0;
	logic in_stall;
	logic [2:0] cmd = '0;
	logic [3:0] proc_index = '0;
	logic [2:0] res_index = '0;
	logic [7:0] value = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [2:0] status;
	logic [3:0] seq_proc;
	logic last;

	bankers_safety_and_request_check i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// model state
	int unsigned bk_nproc = 16, bk_nres = 8;
	int unsigned bk_avail[8];
	int unsigned bk_max[16][8];
	int unsigned bk_alloc[16][8];
	int unsigned bk_stage[8];
	int unsigned bk_order[16];

	item_t pending_items[$];
	res_t expected_results[$];
	int mismatches = 0;
	int unsigned rx_hold = 0;
	bit sender_ready = 0;
	bit stim_done = 0;
	bit timed_out = 0;

	// safety walk; returns number of processes placed in the order
	function automatic int unsigned run_safety();
		int unsigned work[8];
		bit fin[16];
		int unsigned cnt;
		bit progress, fits;
		cnt = 0;
		progress = 1;
		for (int j = 0; j < 8; j++) work[j] = bk_avail[j];
		for (int i = 0; i < 16; i++) fin[i] = 0;
		while (cnt < bk_nproc && progress) begin
			progress = 0;
			for (int i = 0; i < bk_nproc; i++) begin
				if (fin[i]) continue;
				fits = 1;
				for (int j = 0; j < bk_nres; j++)
					if (bk_max[i][j] > bk_alloc[i][j] + work[j]) fits = 0;
				if (!fits) continue;
				fin[i] = 1;
				for (int j = 0; j < bk_nres; j++) begin
					work[j] = work[j] + bk_alloc[i][j];
					if (work[j] > WORK_TOP) work[j] = WORK_TOP;
				end
				bk_order[cnt] = i;
				cnt++;
				progress = 1;
			end
		end
		return cnt;
	endfunction

	function automatic void push_one(logic [2:0] st, int unsigned p);
		res_t r;
		r.status = st;
		r.proc = p[3:0];
		r.last = 1;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic void push_order(logic [2:0] st);
		res_t r;
		for (int i = 0; i < bk_nproc; i++) begin
			r.status = st;
			r.proc = bk_order[i][3:0];
			r.last = (i + 1 == bk_nproc);
			expected_results.insert(expected_results.size(), r);
		end
	endfunction

	// predict results of one accepted item
	function automatic void predict_banker(item_t it);
		int unsigned p;
		bit bad;
		p = it.proc;
		case (it.cmd)
			CMD_SET_AVAIL: bk_avail[it.res] = it.value;
			CMD_SET_MAX:   bk_max[p][it.res] = it.value;
			CMD_SET_ALLOC: bk_alloc[p][it.res] = it.value;
			CMD_STAGE_REQ: bk_stage[it.res] = it.value;
			CMD_SAFETY: begin
				if (run_safety() == bk_nproc) push_order(ST_SAFE);
				else push_one(ST_UNSAFE, 0);
			end
			CMD_REQUEST: begin
				bad = (p >= bk_nproc);
				if (!bad)
					for (int j = 0; j < bk_nres; j++)
						if (bk_stage[j] + bk_alloc[p][j] > bk_max[p][j]) bad = 1;
				if (bad) begin
					push_one(ST_CLAIM, p);
				end else begin
					for (int j = 0; j < bk_nres; j++)
						if (bk_stage[j] > bk_avail[j]) bad = 1;
					if (bad) begin
						push_one(ST_WAIT, p);
					end else begin
						// request fits under claim, so allocation stays in 8 bits
						for (int j = 0; j < bk_nres; j++) begin
							bk_avail[j] -= bk_stage[j];
							bk_alloc[p][j] += bk_stage[j];
						end
						if (run_safety() == bk_nproc) begin
							push_order(ST_GRANTED);
						end else begin
							for (int j = 0; j < bk_nres; j++) begin
								bk_avail[j] += bk_stage[j];
								bk_alloc[p][j] -= bk_stage[j];
							end
							push_one(ST_DENIED, p);
						end
					end
				end
			end
			default: ;
		endcase
	endfunction

	// driver: one item per handshake, random gap after each
	int unsigned tx_gap = 0;
	always @(posedge clk) begin
		item_t nx;
		if (in_valid && !in_stall) begin
			predict_banker(item_t'({cmd, proc_index, res_index, value}));
			void'(pending_items.pop_front());
		end
		if (in_valid && in_stall) begin
			// hold payload
		end else if (tx_gap != 0) begin
			tx_gap <= tx_gap - 1;
			in_valid <= 0;
		end else if (sender_ready && pending_items.size() != 0) begin
			nx = pending_items[0];
			{cmd, proc_index, res_index, value} <= nx;
			in_valid <= 1;
			tx_gap <= $urandom_range(11);
		end else begin
			in_valid <= 0;
		end
	end

	// monitor and receiver stall
	int unsigned rx_gap = 0;
	always @(posedge clk) begin
		res_t got, want;
		if (out_valid && !out_stall) begin
			got = {status, seq_proc, last};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result status=%0d proc=%0d last=%0d",
						status, seq_proc, last);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp %0d/%0d/%0d got %0d/%0d/%0d",
							want.status, want.proc, want.last, status, seq_proc, last);
				end
			end
		end
		if (rx_hold != 0) begin
			rx_hold <= rx_hold - 1;
			out_stall <= 1;
		end else if (rx_gap != 0) begin
			rx_gap <= rx_gap - 1;
			out_stall <= 1;
		end else begin
			out_stall <= 0;
			if (out_valid && !out_stall) rx_gap <= $urandom_range(11);
		end
	end

	// watchdog on accepted traffic
	int unsigned idle_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || rx_hold != 0)
			idle_cycles <= 0;
		else if (sender_ready && !stim_done)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_LIMIT && !timed_out) begin
			timed_out = 1;
			$display("tb: done, errors");
			$finish;
		end
	end

	task automatic apb_write(logic [2:0] addr, int unsigned data);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	task automatic set_sizes(int unsigned np, int unsigned nr);
		apb_write(REG_NPROC, np);
		apb_write(REG_NRES, nr);
		bk_nproc = np;
		bk_nres = nr;
	endtask

	// wait until all items are taken and results are in, then let the block settle
	task automatic drain();
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	function automatic void add(logic [2:0] c, int unsigned p, int unsigned r, int unsigned v);
		item_t it;
		it.cmd = c; it.proc = p[3:0]; it.res = r[2:0]; it.value = v[7:0];
		pending_items.insert(pending_items.size(), it);
	endfunction

	// load a full table; max is written before alloc so no entry is ever unwritten
	function automatic void load_table(int unsigned top);
		for (int j = 0; j < 8; j++) add(CMD_SET_AVAIL, $urandom, j, $urandom_range(top));
		for (int i = 0; i < 16; i++)
			for (int j = 0; j < 8; j++) begin
				int unsigned mx;
				mx = $urandom_range(top);
				add(CMD_SET_MAX, i, j, mx);
				add(CMD_SET_ALLOC, i, j,
					($urandom_range(15) == 0) ? $urandom_range(255) : $urandom_range(mx));
			end
		for (int j = 0; j < 8; j++) add(CMD_STAGE_REQ, $urandom, j, $urandom_range(3));
	endfunction

	// rewrite a few claim/allocation pairs inside the active region
	function automatic void touch_table(int unsigned np, int unsigned nr, int unsigned top);
		for (int k = 0; k < 3; k++) begin
			int unsigned p, r, mx;
			p = $urandom_range(np - 1);
			r = $urandom_range(nr - 1);
			mx = $urandom_range(top);
			add(CMD_SET_MAX, p, r, mx);
			add(CMD_SET_ALLOC, p, r, $urandom_range(mx));
		end
	endfunction

	function automatic void random_ops(int unsigned n, int unsigned np);
		for (int k = 0; k < n; k++) begin
			int unsigned sel;
			sel = $urandom_range(9);
			if (sel < 3) add(CMD_STAGE_REQ, $urandom, $urandom_range(7), $urandom_range(4));
			else if (sel < 5) add(CMD_SAFETY, $urandom, $urandom, $urandom);
			else if (sel < 8) add(CMD_REQUEST,
				($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(np - 1),
				$urandom, $urandom);
			else if (sel == 8) add(CMD_SET_AVAIL, $urandom, $urandom_range(7), $urandom_range(255));
			else add(3'($urandom_range(6, 7)), $urandom, $urandom, $urandom);
		end
	endfunction

	initial begin
		int unsigned cfg_np[5];
		int unsigned cfg_nr[5];
		cfg_np = '{1, 16, 3, 9, 16};
		cfg_nr = '{8, 1, 3, 8, 8};
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// table writes at reset sizes
		load_table(12);
		sender_ready = 1;
		drain();
		// directed: extremes, every command, unused codes, unsafe and denied paths
		add(CMD_SET_AVAIL, 15, 7, 255);
		add(CMD_SET_MAX, 15, 7, 255);
		add(CMD_SET_ALLOC, 15, 7, 0);
		add(CMD_SAFETY, 0, 0, 0);
		add(CMD_STAGE_REQ, 0, 7, 255);
		add(CMD_REQUEST, 15, 0, 0);
		add(CMD_SET_ALLOC, 14, 0, 255);
		add(CMD_SAFETY, 0, 0, 0);
		add(CMD_REQUEST, 14, 0, 0);
		add(3'd6, 0, 0, 0);
		add(3'd7, 15, 7, 255);
		for (int j = 0; j < 8; j++) add(CMD_SET_AVAIL, 0, j, 0);
		add(CMD_SAFETY, 0, 0, 0);
		add(CMD_STAGE_REQ, 0, 0, 1);
		add(CMD_REQUEST, 3, 0, 0);
		drain();
		for (int ph = 0; ph < 5; ph++) begin
			set_sizes(cfg_np[ph], cfg_nr[ph]);
			touch_table(cfg_np[ph], cfg_nr[ph], (ph & 1) ? 255 : 10);
			if (ph == 2) begin
				drain();
				// receiver holds off while the sender keeps offering items
				rx_hold <= 400;
				add(CMD_SAFETY, 0, 0, 0);
				add(CMD_SAFETY, 0, 0, 0);
			end
			random_ops(10, cfg_np[ph]);
			drain();
		end
		stim_done = 1;
		if (mismatches == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end
endmodule

### sim.f
design/bsrc_pkg.sv
design/bsrc_dp.sv
design/bsrc_ctrl.sv
design/bankers_safety_and_request_check.sv
design/bsrc_checker.sv
bench/tb.sv
